// ----- hdl/snd_pkg.sv -----
// ----------------------------------------------------------------------------
// snd_pkg
// shared types and constants of the sobel / suppression / threshold block
// ----------------------------------------------------------------------------
package snd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int GREY_W     = 8;
   localparam int RING       = 2 * MAX_WIDTH + 3;
   localparam int RING_AW    = $clog2(RING);
   localparam int CFG_W      = 11;
   localparam int POS_W      = 10;
   localparam int MAG_W      = 11;
   localparam int MAG_MAX    = 2047;

   // register indexes
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_LOW_THRESH   = 2'd2;
   localparam logic [1:0] REG_HIGH_THRESH  = 2'd3;

   // direction codes
   localparam logic [1:0] DIR_HORIZ = 2'd0;
   localparam logic [1:0] DIR_DIAG45 = 2'd1;
   localparam logic [1:0] DIR_VERT = 2'd2;
   localparam logic [1:0] DIR_DIAG135 = 2'd3;

   // edge classes
   localparam logic [1:0] CLASS_NONE   = 2'd0;
   localparam logic [1:0] CLASS_WEAK   = 2'd1;
   localparam logic [1:0] CLASS_STRONG = 2'd2;

   typedef enum logic [1:0] {
      OFF_NEG,
      OFF_ZERO,
      OFF_POS
   } offset_type;

   // one item handed from front to back
   typedef struct packed {
      logic [GREY_W-1:0]  grey;
      logic [RING_AW-1:0] ring_pos;
      logic               sob_int;
      logic               sup_int;
      logic               out_vld;
      logic [POS_W-1:0]   px;
      logic [POS_W-1:0]   py;
      logic               last;
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GWR,
      ST_GRD,
      ST_GCAP,
      ST_SOB,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_DIR,
      ST_SQRT,
      ST_MWR,
      ST_CRD,
      ST_CCAP,
      ST_PRD,
      ST_PCAP,
      ST_QRD,
      ST_QCAP,
      ST_OUT
   } state_type;

endpackage

// ----- hdl/sobel_nms_double_threshold.sv -----
// ----------------------------------------------------------------------------
// sobel_nms_double_threshold
// sobel gradient, direction, double threshold and non-maximum suppression
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the req stream and one result per pixel
// leaves on the rsp stream 2*W+2 transactions after the pixel went in, so
// 2*W+2 pad transactions must follow each frame to drain it. In the back end
// the line stores have a single read port, so the eight grey taps and three
// magnitude taps are fetched one at a time, each read state followed by a
// capture state, and the square root runs one result bit per cycle (11 steps).
// The front end and a two-entry queue take new pixels while the back end works.
// Registers (apb, byte address 4*i): frame_width, frame_height,
// low_threshold, high_threshold, 11 bits each; write them only while idle.
module sobel_nms_double_threshold import snd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // pixel input: red[7:0], green[15:8], blue[23:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // pad flag
   input  logic        req_tuser,
   // result: pixel_x[9:0], pixel_y[19:10], magnitude[30:20], direction[32:31],
   // edge_class[34:33], nms_edge[35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // configuration
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [CFG_W-1:0] width_ff, height_ff, low_ff, high_ff;
   logic [CFG_W-1:0] eff_w, eff_h;
   logic             wr_en, in_accept, q_full, q_empty, q_pop;
   cmd_type          f_cmd, q_cmd;

   // register write on the access cycle
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(640);
         height_ff <= CFG_W'(480);
         low_ff    <= CFG_W'(150);
         high_ff   <= CFG_W'(200);
      end else if (wr_en) begin
         case (paddr[3:2])
            REG_FRAME_WIDTH:  width_ff  <= pwdata[CFG_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= pwdata[CFG_W-1:0];
            REG_LOW_THRESH:   low_ff    <= pwdata[CFG_W-1:0];
            default:          high_ff   <= pwdata[CFG_W-1:0];
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_FRAME_WIDTH:  prdata = {21'b0, width_ff};
         REG_FRAME_HEIGHT: prdata = {21'b0, height_ff};
         REG_LOW_THRESH:   prdata = {21'b0, low_ff};
         default:          prdata = {21'b0, high_ff};
      endcase
   end

   // frame size clamped to what the line stores hold
   always_comb begin
      eff_w = width_ff;
      if (eff_w < CFG_W'(3)) eff_w = CFG_W'(3);
      if (eff_w > CFG_W'(MAX_WIDTH)) eff_w = CFG_W'(MAX_WIDTH);
      eff_h = height_ff;
      if (eff_h < CFG_W'(3)) eff_h = CFG_W'(3);
      if (eff_h > CFG_W'(MAX_HEIGHT)) eff_h = CFG_W'(MAX_HEIGHT);
   end

   assign req_tready = ~q_full;
   assign in_accept  = req_tvalid & ~q_full;

   snd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .eff_w  (eff_w),
      .eff_h  (eff_h),
      .accept (in_accept),
      .red    (req_tdata[7:0]),
      .green  (req_tdata[15:8]),
      .blue   (req_tdata[23:16]),
      .pad    (req_tuser),
      .cmd    (f_cmd)
   );

   snd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (in_accept),
      .push_data (f_cmd),
      .pop       (q_pop),
      .pop_data  (q_cmd),
      .full      (q_full),
      .empty     (q_empty)
   );

   snd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .eff_w       (eff_w),
      .low_thresh  (low_ff),
      .high_thresh (high_ff),
      .q_empty     (q_empty),
      .q_data      (q_cmd),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

endmodule

// ----- hdl/snd_front.sv -----
// ----------------------------------------------------------------------------
// snd_front
// accepts pixels, forms grey, tracks position and classifies each transaction
// ----------------------------------------------------------------------------
module snd_front import snd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CFG_W-1:0]  eff_w,
   input  logic [CFG_W-1:0]  eff_h,
   input  logic              accept,
   input  logic [7:0]        red,
   input  logic [7:0]        green,
   input  logic [7:0]        blue,
   input  logic              pad,
   output cmd_type           cmd
);

   logic [POS_W-1:0]   col_ff, col_in;
   logic [CFG_W-1:0]   row_ff, row_in;
   logic [RING_AW-1:0] pos_ff, pos_in;
   logic [CFG_W-1:0]   col_nx;

   logic [9:0]         sum;
   logic [19:0]        prod;
   logic signed [12:0] sw, sh, xa, ya, xb, yb, sc, sr;
   logic               done;

   function automatic logic inside_core(input logic signed [12:0] x, input logic signed [12:0] y,
                                        input logic signed [12:0] w, input logic signed [12:0] h);
      inside_core = (x >= 13'sd1) && (x <= w - 13'sd2) && (y >= 13'sd1) && (y <= h - 13'sd2);
   endfunction

   always_comb begin
      sum  = {2'b0, red} + {2'b0, green} + {2'b0, blue};
      // divide by three through a reciprocal multiply
      prod = {10'b0, sum} * 20'd683;
      sw = $signed({2'b0, eff_w});
      sh = $signed({2'b0, eff_h});
      sc = $signed({3'b0, col_ff});
      sr = $signed({2'b0, row_ff});
      if (sc >= 13'sd1) begin
         xa = sc - 13'sd1;
         ya = sr - 13'sd1;
      end else begin
         xa = sw - 13'sd1;
         ya = sr - 13'sd2;
      end
      if (xa >= 13'sd1) begin
         xb = xa - 13'sd1;
         yb = ya - 13'sd1;
      end else begin
         xb = sw - 13'sd1;
         yb = ya - 13'sd2;
      end
      cmd.grey     = pad ? '0 : prod[18:11];
      cmd.ring_pos = pos_ff;
      cmd.sob_int  = inside_core(xa, ya, sw, sh);
      cmd.sup_int  = inside_core(xb, yb, sw, sh);
      cmd.out_vld  = (xb >= 13'sd0) && (xb < sw) && (yb >= 13'sd0) && (yb < sh);
      cmd.px       = xb[POS_W-1:0];
      cmd.py       = yb[POS_W-1:0];
      cmd.last     = (xb == sw - 13'sd1) && (yb == sh - 13'sd1);
      done         = cmd.out_vld && cmd.last;

      pos_in = (pos_ff == RING_AW'(RING - 1)) ? '0 : pos_ff + 1'b1;
      // one bit wider so a full-width row does not wrap before the compare
      col_nx = {1'b0, col_ff} + 1'b1;
      col_in = col_nx[POS_W-1:0];
      row_in = row_ff;
      if (col_nx >= eff_w) begin
         col_in = '0;
         row_in = row_ff + 1'b1;
      end
      if (done || ({1'b0, row_in} >= {1'b0, eff_h} + 12'd3)) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         pos_ff <= pos_in;
      end
   end

endmodule

// ----- hdl/snd_queue.sv -----
// ----------------------------------------------------------------------------
// snd_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module snd_queue import snd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    full,
   output logic    empty
);

   cmd_type    entry_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      full   = (cnt_ff == 2'd2);
      empty  = (cnt_ff == 2'd0);
      pop_data = entry_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_data;
   end

endmodule

// ----- hdl/snd_back.sv -----
// ----------------------------------------------------------------------------
// snd_back
// line stores, sobel, root, direction, threshold, suppression and the result register
// ----------------------------------------------------------------------------
module snd_back import snd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [CFG_W-1:0]  eff_w,
   input  logic [CFG_W-1:0]  low_thresh,
   input  logic [CFG_W-1:0]  high_thresh,
   input  logic              q_empty,
   input  cmd_type           q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [39:0]       rsp_data,
   output logic              rsp_last
);

   state_type state_ff, state_in;
   cmd_type   cmd_ff;

   logic [GREY_W-1:0] grey_mem [RING];
   logic [MAG_W-1:0]  mag_mem  [RING];
   logic [1:0]        dir_mem  [RING];
   logic [GREY_W-1:0] grey_rd_ff;
   logic [MAG_W-1:0]  mag_rd_ff;
   logic [1:0]        dir_rd_ff;
   logic [RING_AW-1:0] rd_addr;
   logic grey_we, mag_we;

   logic [GREY_W-1:0] win_ff [8];
   logic [2:0]  k_ff;
   logic [10:0] ax_ff, ay_ff;
   logic        gx_neg_ff, gy_neg_ff;
   logic [21:0] ax2_ff, ay2_ff, s_ff;
   logic [10:0] mul_op;
   logic [21:0] mul_p;
   logic [21:0] v_ff, r_ff, bit_ff;
   logic [MAG_W-1:0] m_res_ff, m_c_ff, m_p_ff, m_q_ff;
   logic [1:0]  dir_res_ff, dr_ff;

   logic        rsp_valid_ff;
   logic [39:0] rsp_data_ff;
   logic        rsp_last_ff;

   logic signed [12:0] gx, gy;
   logic [21:0] trial;
   logic [1:0]  cls;
   logic        nms;

   function automatic logic [RING_AW-1:0] tap_addr(input logic [RING_AW-1:0] pos,
         input logic [CFG_W-1:0] w, input offset_type dx, input offset_type dy);
      logic [12:0] d;
      logic [12:0] a;
      d = {2'b0, w} + 13'd1;
      if (dy == OFF_NEG) d = d + {2'b0, w};
      if (dy == OFF_POS) d = d - {2'b0, w};
      if (dx == OFF_NEG) d = d + 13'd1;
      if (dx == OFF_POS) d = d - 13'd1;
      if ({1'b0, pos} >= d) a = {1'b0, pos} - d;
      else a = {1'b0, pos} + 13'(RING) - d;
      tap_addr = a[RING_AW-1:0];
   endfunction

   function automatic offset_type tap_dx(input logic [2:0] k);
      case (k)
         3'd0, 3'd3, 3'd5: tap_dx = OFF_NEG;
         3'd1, 3'd6:       tap_dx = OFF_ZERO;
         default:          tap_dx = OFF_POS;
      endcase
   endfunction

   function automatic offset_type tap_dy(input logic [2:0] k);
      case (k)
         3'd0, 3'd1, 3'd2: tap_dy = OFF_NEG;
         3'd3, 3'd4:       tap_dy = OFF_ZERO;
         default:          tap_dy = OFF_POS;
      endcase
   endfunction

   // memories
   always_ff @(posedge clock) begin
      if (grey_we) grey_mem[cmd_ff.ring_pos] <= cmd_ff.grey;
      grey_rd_ff <= grey_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mag_we) mag_mem[cmd_ff.ring_pos] <= m_res_ff;
      mag_rd_ff <= mag_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mag_we) dir_mem[cmd_ff.ring_pos] <= dir_res_ff;
      dir_rd_ff <= dir_mem[rd_addr];
   end

   always_comb begin
      gx = $signed({5'b0, win_ff[2]}) - $signed({5'b0, win_ff[0]})
         - 13'sd2 * $signed({5'b0, win_ff[3]}) + 13'sd2 * $signed({5'b0, win_ff[4]})
         - $signed({5'b0, win_ff[5]}) + $signed({5'b0, win_ff[7]});
      gy = $signed({5'b0, win_ff[5]}) - $signed({5'b0, win_ff[0]})
         - 13'sd2 * $signed({5'b0, win_ff[1]}) + 13'sd2 * $signed({5'b0, win_ff[6]})
         + $signed({5'b0, win_ff[7]}) - $signed({5'b0, win_ff[2]});
      case (state_ff)
         ST_MUL0: mul_op = ax_ff;
         ST_MUL1: mul_op = ay_ff;
         default: mul_op = ax_ff + ay_ff;
      endcase
      mul_p = {11'b0, mul_op} * {11'b0, mul_op};
      trial = r_ff + bit_ff;
      cls = (m_c_ff < low_thresh) ? CLASS_NONE
          : ((m_c_ff < high_thresh) ? CLASS_WEAK : CLASS_STRONG);
      nms = (m_c_ff > m_p_ff) && (m_c_ff > m_q_ff);
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      grey_we  = 1'b0;
      mag_we   = 1'b0;
      rd_addr  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = ST_GWR;
            end
         end
         ST_GWR: begin
            grey_we  = 1'b1;
            state_in = ST_GRD;
         end
         ST_GRD: begin
            rd_addr  = tap_addr(cmd_ff.ring_pos, eff_w, tap_dx(k_ff), tap_dy(k_ff));
            state_in = ST_GCAP;
         end
         ST_GCAP: state_in = (k_ff == 3'd7) ? ST_SOB : ST_GRD;
         ST_SOB:  state_in = ST_MUL0;
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_DIR;
         ST_DIR:  state_in = ST_SQRT;
         ST_SQRT: state_in = (bit_ff == 22'd1) ? ST_MWR : ST_SQRT;
         ST_MWR: begin
            mag_we   = 1'b1;
            state_in = ST_CRD;
         end
         ST_CRD: begin
            rd_addr  = tap_addr(cmd_ff.ring_pos, eff_w, OFF_ZERO, OFF_ZERO);
            state_in = ST_CCAP;
         end
         ST_CCAP: state_in = ST_PRD;
         ST_PRD: begin
            case (dr_ff)
               DIR_HORIZ:  rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_NEG, OFF_ZERO);
               DIR_DIAG45: rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_NEG, OFF_NEG);
               DIR_VERT:   rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_ZERO, OFF_NEG);
               default:    rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_POS, OFF_NEG);
            endcase
            state_in = ST_PCAP;
         end
         ST_PCAP: state_in = ST_QRD;
         ST_QRD: begin
            case (dr_ff)
               DIR_HORIZ:  rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_POS, OFF_ZERO);
               DIR_DIAG45: rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_POS, OFF_POS);
               DIR_VERT:   rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_ZERO, OFF_POS);
               default:    rd_addr = tap_addr(cmd_ff.ring_pos, eff_w, OFF_NEG, OFF_POS);
            endcase
            state_in = ST_QCAP;
         end
         ST_QCAP: state_in = ST_OUT;
         ST_OUT: begin
            if (!cmd_ff.out_vld) state_in = ST_IDLE;
            else if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            cmd_ff <= q_data;
            k_ff   <= '0;
         end
         ST_GCAP: begin
            win_ff[k_ff] <= grey_rd_ff;
            k_ff         <= k_ff + 1'b1;
         end
         ST_SOB: begin
            ax_ff     <= gx[12] ? 11'(-gx) : gx[10:0];
            ay_ff     <= gy[12] ? 11'(-gy) : gy[10:0];
            gx_neg_ff <= gx[12];
            gy_neg_ff <= gy[12];
         end
         ST_MUL0: ax2_ff <= mul_p;
         ST_MUL1: ay2_ff <= mul_p;
         ST_MUL2: s_ff   <= mul_p;
         ST_DIR: begin
            if (ax_ff == '0 && ay_ff == '0) dir_res_ff <= DIR_HORIZ;
            else if ({1'b0, s_ff} < {ax2_ff, 1'b0}) dir_res_ff <= DIR_HORIZ;
            else if ({1'b0, s_ff} < {ay2_ff, 1'b0}) dir_res_ff <= DIR_VERT;
            else dir_res_ff <= (gx_neg_ff == gy_neg_ff) ? DIR_DIAG45 : DIR_DIAG135;
            v_ff   <= ax2_ff + ay2_ff;
            r_ff   <= '0;
            bit_ff <= 22'd1 << 20;
         end
         ST_SQRT: begin
            if (v_ff >= trial) begin
               v_ff <= v_ff - trial;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff == 22'd1) begin
               m_res_ff <= cmd_ff.sob_int ? ((v_ff >= trial) ?
                           (((r_ff >> 1) + bit_ff > 22'(MAG_MAX)) ? MAG_W'(MAG_MAX)
                            : 11'((r_ff >> 1) + bit_ff))
                           : (((r_ff >> 1) > 22'(MAG_MAX)) ? MAG_W'(MAG_MAX)
                              : 11'(r_ff >> 1))) : '0;
               if (!cmd_ff.sob_int) dir_res_ff <= DIR_HORIZ;
            end
         end
         ST_CCAP: begin
            m_c_ff <= mag_rd_ff;
            dr_ff  <= dir_rd_ff;
         end
         ST_PCAP: m_p_ff <= mag_rd_ff;
         // second neighbor held here, the read port moves on afterwards
         ST_QCAP: m_q_ff <= mag_rd_ff;
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && cmd_ff.out_vld && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && cmd_ff.out_vld && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data_ff <= {4'b0,
                         cmd_ff.sup_int ? nms : 1'b0,
                         cmd_ff.sup_int ? cls : CLASS_NONE,
                         cmd_ff.sup_int ? dr_ff : DIR_HORIZ,
                         cmd_ff.sup_int ? m_c_ff : {MAG_W{1'b0}},
                         cmd_ff.py, cmd_ff.px};
         rsp_last_ff <= cmd_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// ----- tb/sobel_nms_double_threshold_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_nms_double_threshold_checker
// watches both streams and the register port, predicts every result
// transaction of the edge block and compares it field by field
// ----------------------------------------------------------------------------
module sobel_nms_double_threshold_checker import snd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // red[7:0], green[15:8], blue[23:16]
   input  logic [23:0] req_tdata,
   // pad flag
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_x[9:0], pixel_y[19:10], magnitude[30:20], direction[32:31],
   // edge_class[34:33], nms_edge[35]
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   typedef struct packed {
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [MAG_W-1:0] mag;
      logic [1:0]       dir;
      logic [1:0]       cls;
      logic             nms;
      logic             last;
   } edge_result_type;

   edge_result_type  edge_results_q[$];

   logic [CFG_W-1:0] width_reg, height_reg, low_reg, high_reg;
   logic [7:0]       grey_ring[RING];
   logic [MAG_W-1:0] mag_ring[RING];
   logic [1:0]       dir_ring[RING];
   int               wr_pos, col, row;

   assign pending = edge_results_q.size();

   function automatic int int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 30;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return int'(r);
   endfunction

   // ring index of the transaction that arrived 'back' steps ago
   function automatic int ring_at(input int back);
      return (wr_pos + RING - (back % RING)) % RING;
   endfunction

   function automatic int tap(input int w, input int dx, input int dy);
      return ring_at(w + 1 - dy * w - dx);
   endfunction

   function automatic bit is_inner(input int x, input int y, input int w, input int h);
      return x >= 1 && x <= w - 2 && y >= 1 && y <= h - 2;
   endfunction

   task automatic predict_pixel(input logic [23:0] rgb, input logic pad);
      int              w, h, grey, xa, ya, xb, yb, m, pm, qm;
      int              a, b, c, d, f, g, hh, i, gx, gy;
      longint          ax, ay, s;
      logic [1:0]      dir, dr;
      edge_result_type res;
      bit              done;
      w = width_reg < 3 ? 3 : (width_reg > MAX_WIDTH ? MAX_WIDTH : int'(width_reg));
      h = height_reg < 3 ? 3 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : int'(height_reg));
      grey = pad ? 0 : (int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16])) / 3;
      grey_ring[wr_pos] = grey[7:0];
      m = 0;
      dir = DIR_HORIZ;
      done = 0;
      // gradient centre sits w+1 transactions back
      xa = col;
      ya = row;
      if (xa >= 1) begin xa -= 1; ya -= 1; end else begin xa = w - 1; ya -= 2; end
      if (is_inner(xa, ya, w, h)) begin
         a = grey_ring[tap(w, -1, -1)]; b = grey_ring[tap(w, 0, -1)];
         c = grey_ring[tap(w, 1, -1)];  d = grey_ring[tap(w, -1, 0)];
         f = grey_ring[tap(w, 1, 0)];   g = grey_ring[tap(w, -1, 1)];
         hh = grey_ring[tap(w, 0, 1)];  i = grey_ring[tap(w, 1, 1)];
         gx = c - a - 2 * d + 2 * f - g + i;
         gy = g - a - 2 * b + 2 * hh + i - c;
         ax = gx < 0 ? -gx : gx;
         ay = gy < 0 ? -gy : gy;
         s = (ax + ay) * (ax + ay);
         m = int_sqrt(ax * ax + ay * ay);
         if (m > MAG_MAX) m = MAG_MAX;
         if (ax == 0 && ay == 0) dir = DIR_HORIZ;
         else if (s < 2 * ax * ax) dir = DIR_HORIZ;
         else if (s < 2 * ay * ay) dir = DIR_VERT;
         else dir = ((gx < 0) == (gy < 0)) ? DIR_DIAG45 : DIR_DIAG135;
      end
      mag_ring[wr_pos] = m[MAG_W-1:0];
      dir_ring[wr_pos] = dir;
      // suppression centre a further w+1 back
      xb = xa;
      yb = ya;
      if (xb >= 1) begin xb -= 1; yb -= 1; end else begin xb = w - 1; yb -= 2; end
      if (xb >= 0 && xb < w && yb >= 0 && yb < h) begin
         res = '0;
         res.px = xb[POS_W-1:0];
         res.py = yb[POS_W-1:0];
         if (is_inner(xb, yb, w, h)) begin
            m = mag_ring[tap(w, 0, 0)];
            dr = dir_ring[tap(w, 0, 0)];
            res.mag = m[MAG_W-1:0];
            res.dir = dr;
            res.cls = m < low_reg ? CLASS_NONE : (m < high_reg ? CLASS_WEAK : CLASS_STRONG);
            case (dr)
               DIR_HORIZ: begin
                  pm = mag_ring[tap(w, -1, 0)]; qm = mag_ring[tap(w, 1, 0)];
               end
               DIR_DIAG45: begin
                  pm = mag_ring[tap(w, -1, -1)]; qm = mag_ring[tap(w, 1, 1)];
               end
               DIR_VERT: begin
                  pm = mag_ring[tap(w, 0, -1)]; qm = mag_ring[tap(w, 0, 1)];
               end
               default: begin
                  pm = mag_ring[tap(w, 1, -1)]; qm = mag_ring[tap(w, -1, 1)];
               end
            endcase
            res.nms = m > pm && m > qm;
         end
         res.last = xb == w - 1 && yb == h - 1;
         done = res.last;
         edge_results_q = {edge_results_q, res};
      end
      wr_pos = (wr_pos + 1) % RING;
      col++;
      if (col >= w) begin col = 0; row++; end
      if (done || row >= h + 3) begin col = 0; row = 0; end
   endtask

   always @(posedge clock) begin
      edge_result_type exp_r, got_r;
      if (reset) begin
         width_reg = 11'd640;
         height_reg = 11'd480;
         low_reg = 11'd150;
         high_reg = 11'd200;
         wr_pos = 0;
         col = 0;
         row = 0;
         edge_results_q.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_FRAME_WIDTH:  width_reg = pwdata[CFG_W-1:0];
               REG_FRAME_HEIGHT: height_reg = pwdata[CFG_W-1:0];
               REG_LOW_THRESH:   low_reg = pwdata[CFG_W-1:0];
               default:          high_reg = pwdata[CFG_W-1:0];
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got_r = {rsp_tdata[9:0], rsp_tdata[19:10], rsp_tdata[30:20], rsp_tdata[32:31],
                     rsp_tdata[34:33], rsp_tdata[35], rsp_tlast};
            if (edge_results_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result transaction, expected none, got %h",
                        $realtime, got_r);
            end else begin
               exp_r = edge_results_q.pop_front();
               checked++;
               if (got_r.px !== exp_r.px) begin
                  fail_count++;
                  $display("%0t: pixel_x expected %0d got %0d", $realtime, exp_r.px, got_r.px);
               end
               if (got_r.py !== exp_r.py) begin
                  fail_count++;
                  $display("%0t: pixel_y expected %0d got %0d", $realtime, exp_r.py, got_r.py);
               end
               if (got_r.mag !== exp_r.mag) begin
                  fail_count++;
                  $display("%0t: magnitude expected %0d got %0d", $realtime,
                           exp_r.mag, got_r.mag);
               end
               if (got_r.dir !== exp_r.dir) begin
                  fail_count++;
                  $display("%0t: direction expected %0d got %0d", $realtime,
                           exp_r.dir, got_r.dir);
               end
               if (got_r.cls !== exp_r.cls) begin
                  fail_count++;
                  $display("%0t: edge_class expected %0d got %0d", $realtime,
                           exp_r.cls, got_r.cls);
               end
               if (got_r.nms !== exp_r.nms) begin
                  fail_count++;
                  $display("%0t: nms_edge expected %0d got %0d", $realtime,
                           exp_r.nms, got_r.nms);
               end
               if (got_r.last !== exp_r.last) begin
                  fail_count++;
                  $display("%0t: last expected %0d got %0d", $realtime,
                           exp_r.last, got_r.last);
               end
            end
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata, req_tuser);
      end
   end

endmodule

// ----- tb/sobel_nms_double_threshold_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_nms_double_threshold_tb
// frame stimulus and verdict for the sobel / suppression / threshold block
// ----------------------------------------------------------------------------
// Streams whole frames of rgb pixels, each followed by its drain run, under
// several frame sizes and threshold pairs; the checker predicts and compares.
module sobel_nms_double_threshold_tb import snd_pkg::*; ();

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   int fail_count, pending, checked;
   int frames_sent = 0;
   int pixels_sent = 0;

   // calm: no random idling on either side
   bit calm = 1'b0;
   // one long receiver hold-off, requested once by the stimulus
   bit hold_req = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sobel_nms_double_threshold dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   sobel_nms_double_threshold_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   // receiver: random stalls, plus one long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 2500;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 13);
      end
   end

   // register write: setup cycle and access cycle, then the bus returns to idle
   task automatic csr_write(input logic [1:0] idx, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // offer one pixel transaction and return at the edge that takes it
   task automatic send_pixel(input logic [23:0] rgb, input logic pad);
      while (!calm && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rgb;
      req_tuser <= pad;
      pixels_sent++;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // wait until every predicted result has come out, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_phase(input int w, input int h, input int lo, input int hi);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_LOW_THRESH, lo);
      csr_write(REG_HIGH_THRESH, hi);
   endtask

   // one frame plus its drain run; style 0 noise, 1 smooth ramp, 2 binary
   task automatic send_frame(input int w_reg, input int h_reg, input int style);
      int w, h, kx, ky, base, v, drain;
      logic [23:0] rgb;
      logic pad;
      w = w_reg < 3 ? 3 : (w_reg > MAX_WIDTH ? MAX_WIDTH : w_reg);
      h = h_reg < 3 ? 3 : (h_reg > MAX_HEIGHT ? MAX_HEIGHT : h_reg);
      kx = $urandom_range(60) - 30;
      ky = $urandom_range(60) - 30;
      base = $urandom_range(255);
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            pad = $urandom_range(99) < 4;
            case (style)
               0: rgb = 24'($urandom);
               1: begin
                  v = base + kx * x + ky * y + $urandom_range(8) - 4;
                  v = v < 0 ? 0 : (v > 255 ? 255 : v);
                  rgb = {v[7:0], v[7:0], v[7:0]};
               end
               default: rgb = $urandom_range(1) ? 24'hffffff : 24'h000000;
            endcase
            send_pixel(rgb, pad);
         end
      end
      // drain: mostly pads, now and then a pixel that must be discarded
      drain = 2 * w + 2;
      for (int i = 0; i < drain; i++) begin
         pad = $urandom_range(99) >= 10;
         send_pixel(24'($urandom), pad);
      end
      frames_sent++;
   endtask

   initial begin
      int w, h, lo, hi;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 4x3 frame of stripes at the color extremes, reset thresholds
      csr_write(REG_FRAME_WIDTH, 4);
      csr_write(REG_FRAME_HEIGHT, 3);
      calm = 1'b1;
      for (int i = 0; i < 12; i++) begin
         case (i % 4)
            0: send_pixel(24'h000000, 1'b0);
            1: send_pixel(24'hffffff, 1'b0);
            2: send_pixel(24'hffffff, 1'b1);
            default: send_pixel(24'hff00ff, 1'b0);
         endcase
      end
      for (int i = 0; i < 10; i++) send_pixel(24'h000000, 1'b1);
      calm = 1'b0;
      frames_sent++;
      wait_drained();

      // wide row with a height below the minimum, which clamps to three rows
      set_phase(100, 0, 0, 2047);
      send_frame(100, 0, 0);
      wait_drained();
      // width below the minimum with a taller frame
      set_phase(0, 40, 2047, 0);
      send_frame(0, 40, 1);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      set_phase(12, 8, 100, 400);
      calm = 1'b1;
      hold_req = 1'b1;
      send_frame(12, 8, 0);
      calm = 1'b0;
      wait_drained();

      // random frames, mostly small
      while (pixels_sent < 1000) begin
         w = $urandom_range(99) < 10 ? $urandom_range(2) : $urandom_range(12, 3);
         h = $urandom_range(99) < 10 ? $urandom_range(2) : $urandom_range(8, 3);
         lo = $urandom_range(99) < 10 ? 0 : $urandom_range(800);
         hi = $urandom_range(99) < 10 ? 2047 : lo + $urandom_range(900);
         if ($urandom_range(99) < 5) begin
            lo = 2047;
            hi = $urandom_range(100);
         end
         calm = $urandom_range(99) < 15;
         set_phase(w, h, lo, hi);
         send_frame(w, h, $urandom_range(2));
         calm = 1'b0;
         wait_drained();
      end

      $display("covered %0d frames, %0d input transactions, %0d results compared",
               frames_sent, pixels_sent, checked);
      $display("sizes from the clamped minimum up to a hundred-pixel row, thresholds at both ends");
      if (fail_count == 0) begin
         $display("sobel_nms_double_threshold_tb: done, clean");
      end else begin
         $display("sobel_nms_double_threshold_tb: done, errors");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #40_000_000;
      $display("sobel_nms_double_threshold_tb: done, errors");
      $finish;
   end

endmodule
